### sv/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and the twiddle table of the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int DATA_W = 24;
  localparam int SAMPLE_W = 16;
  localparam int TW_W = 16;
  localparam int MAX_LG = 6;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t im;
    data_t re;
  } cplx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PERM,
    ST_BFLY_RD,
    ST_BFLY_MUL,
    ST_BFLY_WR,
    ST_OUT
  } state_t;

  function automatic logic signed [TW_W-1:0] tw_cos(input logic [4:0] k);
    logic signed [TW_W-1:0] r;
    case (k)
      5'd0: r = 16'sd32767;   5'd1: r = 16'sd32610;   5'd2: r = 16'sd32138;
      5'd3: r = 16'sd31357;   5'd4: r = 16'sd30274;   5'd5: r = 16'sd28899;
      5'd6: r = 16'sd27246;   5'd7: r = 16'sd25330;   5'd8: r = 16'sd23170;
      5'd9: r = 16'sd20788;   5'd10: r = 16'sd18205;  5'd11: r = 16'sd15447;
      5'd12: r = 16'sd12540;  5'd13: r = 16'sd9512;   5'd14: r = 16'sd6393;
      5'd15: r = 16'sd3212;   5'd16: r = 16'sd0;      5'd17: r = -16'sd3212;
      5'd18: r = -16'sd6393;  5'd19: r = -16'sd9512;  5'd20: r = -16'sd12540;
      5'd21: r = -16'sd15447; 5'd22: r = -16'sd18205; 5'd23: r = -16'sd20788;
      5'd24: r = -16'sd23170; 5'd25: r = -16'sd25330; 5'd26: r = -16'sd27246;
      5'd27: r = -16'sd28899; 5'd28: r = -16'sd30274; 5'd29: r = -16'sd31357;
      5'd30: r = -16'sd32138; default: r = -16'sd32610;
    endcase
    return r;
  endfunction

  // The negated sine at k equals minus the cosine at k - 16 for the upper half.
  // At a quarter turn the table holds the full negative value.
  function automatic logic signed [TW_W-1:0] tw_nsin(input logic [4:0] k);
    logic signed [TW_W-1:0] r;
    if (k == 5'd0) begin
      r = '0;
    end else if (k == 5'd16) begin
      r = 16'sh8000;
    end else if (k < 5'd16) begin
      r = -tw_cos(5'd16 - k);
    end else begin
      r = -tw_cos(k - 5'd16);
    end
    return r;
  endfunction

  function automatic data_t round_q15(input logic signed [40:0] p);
    logic signed [40:0] v;
    v = p + 41'sd16384;
    return v[15+DATA_W-1:15];
  endfunction

endpackage

### sv/radix2_fft_in_place.sv
// ----------------------------------------------------------------------------
// radix2_fft_in_place
// Radix-2 decimation-in-time FFT with a sample queue and one butterfly unit.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata (low bit up)                          tlast
// s_axis    in         sample_re[15:0], sample_im[31:16]           -
// m_axis    out        bin_re, bin_im, bin_number, pad to 56 bits  final_bin
// Loading takes one cycle a sample, written in bit-reversed order.
// An idle state follows, then (N/2)log2(N) butterflies, each read, multiplied and written back.
// Read-out starts one cycle later and gives one bin a cycle while taken.
// Reset clears the control state; the sample memory needs none.
// Stalls on the output hold the bin; the queue takes samples until full.
module radix2_fft_in_place import r2fft_pkg::*; #(
  parameter int FFT_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample_re, sample_im
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // bin_re, bin_im, bin_number
  output logic        m_axis_tlast   // final_bin
);

  localparam int LG = (FFT_POINTS >= 64) ? 6 : (FFT_POINTS >= 32) ? 5 :
                      (FFT_POINTS >= 16) ? 4 : (FFT_POINTS >= 8) ? 3 : 2;

  logic          q_valid;
  logic          q_ready;
  logic [LG+32:0] q_data;

  r2fft_front #(.LG(LG)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  r2fft_back #(.LG(LG)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

### sv/r2fft_ram.sv
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/r2fft_front.sv
// ----------------------------------------------------------------------------
// r2fft_front
// Accepts samples and passes them, with their frame position, into a queue.
// ----------------------------------------------------------------------------
module r2fft_front import r2fft_pkg::*; #(
  parameter int LG = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [LG+32:0]    q_data
);

  localparam int QD = 2;

  logic [LG+32:0] q_mem [QD];
  logic [1:0]     count;
  logic           wp;
  logic           rp;
  logic [LG-1:0]  load_count;
  logic           push;
  logic           pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q_mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      wp         <= 1'b0;
      rp         <= 1'b0;
      load_count <= '0;
    end else begin
      if (push) begin
        wp         <= ~wp;
        load_count <= load_count + 1'b1;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= {&load_count, load_count, in_data};
    end
  end

endmodule

### sv/r2fft_back.sv
// ----------------------------------------------------------------------------
// r2fft_back
// Stores the frame, runs the butterfly stages on one shared unit and reads out.
// ----------------------------------------------------------------------------
module r2fft_back import r2fft_pkg::*; #(
  parameter int LG = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [LG+32:0]    q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [55:0]       out_data,
  output logic              out_last
);

  localparam int N = 1 << LG;

  state_t state;
  state_t state_next;

  logic [2:0]      stage;
  logic            phase;
  logic [LG-1:0]   bidx;
  cplx_t           a_lo;
  cplx_t           a_hi;
  data_t           tr;
  data_t           ti;
  logic            sel_trivial;
  logic signed [40:0] p_rr;
  logic signed [40:0] p_ii;
  logic signed [40:0] p_ri;
  logic signed [40:0] p_ir;
  logic [4:0]      tw_k;
  logic            ram_we;
  logic [LG-1:0]   ram_waddr;
  logic [47:0]     ram_wdata;
  logic [LG-1:0]   ram_raddr;
  logic [47:0]     ram_rdata;
  logic [LG-1:0]   lo_addr;
  logic [LG-1:0]   hi_addr;
  logic [LG-1:0]   half;
  logic [LG-1:0]   jmask;
  logic [LG-1:0]   rev;
  logic [LG-1:0]   out_idx;
  logic            out_full;
  logic [LG-1:0]   in_idx;
  logic signed [15:0] in_re;
  logic signed [15:0] in_im;
  logic            in_end;
  cplx_t           hold;

  assign in_re  = q_data[15:0];
  assign in_im  = q_data[31:16];
  assign in_idx = q_data[LG+31:32];
  assign in_end = q_data[LG+32];

  always_comb begin
    for (int b = 0; b < LG; b++) begin
      rev[b] = in_idx[LG-1-b];
    end
  end

  assign half  = LG'(1) << stage;
  assign jmask = half - 1'b1;
  assign lo_addr = ((bidx & ~jmask) << 1) | (bidx & jmask);
  assign hi_addr = lo_addr | half;
  assign tw_k = 5'(((bidx & jmask) << (MAX_LG - 1 - stage)));

  r2fft_ram #(.WIDTH(48), .DEPTH(N)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (q_valid && in_end) state_next = ST_PERM;
      ST_PERM:     state_next = ST_BFLY_RD;
      ST_BFLY_RD:  if (phase) state_next = ST_BFLY_MUL;
      ST_BFLY_MUL: state_next = ST_BFLY_WR;
      ST_BFLY_WR: begin
        if (phase && (&bidx[LG-2:0]) && (stage == 3'(LG - 1))) begin
          state_next = ST_OUT;
        end else if (phase) begin
          state_next = ST_BFLY_RD;
        end
      end
      ST_OUT: begin
        if (out_valid && out_ready && out_last) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    q_ready   = (state == ST_LOAD);
    ram_we    = 1'b0;
    ram_waddr = rev;
    ram_wdata = {in_im[15], in_im[15], in_im[15], in_im[15], in_im[15], in_im[15],
                 in_im[15], in_im[15], in_im, in_re[15], in_re[15], in_re[15],
                 in_re[15], in_re[15], in_re[15], in_re[15], in_re[15], in_re};
    ram_raddr = phase ? hi_addr : lo_addr;
    case (state)
      ST_LOAD: ram_we = q_valid;
      ST_BFLY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phase ? hi_addr : lo_addr;
        ram_wdata = phase ? {a_lo.im - ti, a_lo.re - tr} : {a_lo.im + ti, a_lo.re + tr};
      end
      ST_OUT: ram_raddr = (out_valid && out_ready) ? out_idx + 1'b1 : out_idx;
      default: ;
    endcase
  end

  assign sel_trivial = (tw_k == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      phase   <= 1'b0;
      stage   <= '0;
      bidx    <= '0;
      out_idx <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_PERM: begin
          phase <= 1'b0;
          stage <= '0;
          bidx  <= '0;
        end
        ST_BFLY_RD: phase <= ~phase;
        ST_BFLY_WR: begin
          phase <= ~phase;
          if (phase) begin
            if (&bidx[LG-2:0]) begin
              bidx  <= '0;
              stage <= stage + 1'b1;
            end else begin
              bidx <= bidx + 1'b1;
            end
          end
          if (state_next == ST_OUT) begin
            out_idx  <= '0;
            out_full <= 1'b0;
          end
        end
        ST_OUT: begin
          if (!out_full) begin
            out_full <= 1'b1;
          end else if (out_ready) begin
            out_idx <= out_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_BFLY_RD && phase) begin
      a_lo <= {ram_rdata[47:24], ram_rdata[23:0]};
    end
    if (state == ST_BFLY_MUL) begin
      p_rr <= 41'(hold.re * tw_cos(tw_k));
      p_ii <= 41'(hold.im * tw_nsin(tw_k));
      p_ri <= 41'(hold.re * tw_nsin(tw_k));
      p_ir <= 41'(hold.im * tw_cos(tw_k));
      a_hi <= hold;
    end
  end

  assign hold = ram_rdata;

  always_comb begin
    if (sel_trivial) begin
      tr = a_hi.re;
      ti = a_hi.im;
    end else begin
      tr = round_q15(p_rr) - round_q15(p_ii);
      ti = round_q15(p_ri) + round_q15(p_ir);
    end
  end

  assign out_valid = (state == ST_OUT) && out_full;
  assign out_data  = {2'b00, 6'(out_idx), ram_rdata[47:24], ram_rdata[23:0]};
  assign out_last  = (out_idx == LG'(N - 1));

endmodule

### sv/r2fft_checker.sv
// ----------------------------------------------------------------------------
// r2fft_checker
// Port-level checks of the FFT block.
// ----------------------------------------------------------------------------
module r2fft_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_next_bin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
    m_axis_tdata[53:48] == $past(m_axis_tdata[53:48]) + 6'd1)
    else $error("bins out of order");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:54] == 2'b00)
    else $error("padding not zero");

  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> m_axis_tdata[53:48] == 6'd0)
    else $error("frame does not start at bin zero");

endmodule

bind radix2_fft_in_place r2fft_checker u_checker (.*);
